/* hw/rtl/bdq_pkg.sv */
// Package for the bounded double-ended queue.
// Holds the sizes, request and status codes and the controller command type.
// No dependencies.
`default_nettype none

package bdq_pkg;

  // Store geometry
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_FILL
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the accepted request
    logic exec;  // commit the request: indices, count, store access
    logic fill;  // load the result register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/bdq_if.sv */
// Channel interfaces for the deque: request channel and response channel.
// Depends on bdq_pkg.
`default_nettype none

interface bdq_req_if;
  import bdq_pkg::*;

  logic                     valid;
  logic                     ready;
  req_e                     req_type;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface bdq_rsp_if;
  import bdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  status_e                  status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output result_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input result_value, input status, input occupancy,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/bounded_deque.sv */
// Top level of the bounded double-ended queue of signed 32-bit values.
// Depends on bdq_pkg, bdq_if, bdq_ctrl and bdq_datapath.
//
//   Port   Dir  Carries
//   req_i  in   req_type (push front/back, pop front/back), push_value
//   rsp_o  out  result_value, status, occupancy after the request
//
// A request passes through three steps: accept, commit (index update and store
// access), result load; the store's registered read port sets the third step.
// One request is in flight at a time; the result sits in an output register,
// so the next request is accepted while it waits to be taken.
// A commit waits while the previous result is still held and not taken.
// Reset clears indices, count and the response valid flag; the store is not cleared.
`default_nettype none

module bounded_deque (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  bdq_req_if.sink       req_i,
  bdq_rsp_if.source     rsp_o
);
  import bdq_pkg::*;

  ctrl_cmd_t cmd;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  bdq_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (req_i.req_type),
    .push_value_i   (req_i.push_value),
    .result_value_o (rsp_o.result_value),
    .status_o       (rsp_o.status),
    .occupancy_o    (rsp_o.occupancy)
  );

endmodule

`default_nettype wire

/* hw/rtl/bdq_ctrl.sv */
// Controller for the deque: sequences accept, commit and result load,
// and owns the response valid flag. Depends on bdq_pkg.
`default_nettype none

module bdq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  output logic                  rsp_valid_o,
  input  wire logic             rsp_ready_i,
  output bdq_pkg::ctrl_cmd_t    cmd_o
);
  import bdq_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        rsp_valid_q, rsp_valid_d;
  logic        slot_free;

  // State and response flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Result register is free when empty or being taken this cycle
  assign slot_free = !rsp_valid_q || rsp_ready_i;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    unique case (state_q)
      CS_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = CS_EXEC;
        end
      end
      CS_EXEC: begin
        // commit only once the result has somewhere to go
        if (slot_free) begin
          cmd_o.exec = 1'b1;
          state_d    = CS_FILL;
        end
      end
      CS_FILL: begin
        cmd_o.fill  = 1'b1;
        rsp_valid_d = 1'b1;
        state_d     = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

`default_nettype wire

/* hw/rtl/bdq_datapath.sv */
// Datapath for the deque: request register, circular store, front/back
// indices, entry count and result register. Depends on bdq_pkg.
`default_nettype none

module bdq_datapath (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire bdq_pkg::ctrl_cmd_t       cmd_i,
  input  wire bdq_pkg::req_e            req_type_i,
  input  wire logic signed [31:0]       push_value_i,
  output logic signed [31:0]            result_value_o,
  output bdq_pkg::status_e              status_o,
  output logic [bdq_pkg::OCC_W-1:0]     occupancy_o
);
  import bdq_pkg::*;

  // Captured request (payload, no reset)
  req_e                     req_q;
  logic signed [DATA_W-1:0] val_q;

  // Queue control state
  logic [IDX_W-1:0] front_q, front_d;
  logic [IDX_W-1:0] back_q, back_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Store and read port
  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [IDX_W-1:0]  wr_addr, rd_addr;

  // Commit-stage results
  status_e stat_q, stat_d;
  logic    pop_ok_q;

  // Result register (payload)
  logic signed [DATA_W-1:0] res_q;
  status_e                  res_stat_q;
  logic [OCC_W-1:0]         res_occ_q;

  logic is_push, is_front, full, empty, push_ok, pop_ok;
  logic [IDX_W-1:0] front_inc, front_dec, back_inc, back_dec;

  // Index wrap arithmetic
  assign front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
  assign back_inc  = (back_q == IDX_W'(DEPTH - 1)) ? '0 : back_q + 1'b1;
  assign back_dec  = (back_q == '0) ? IDX_W'(DEPTH - 1) : back_q - 1'b1;

  // Request decode
  always_comb begin
    is_push  = 1'b0;
    is_front = 1'b0;
    unique case (req_q)
      REQ_PUSH_FRONT: begin
        is_push  = 1'b1;
        is_front = 1'b1;
      end
      REQ_PUSH_BACK:  is_push  = 1'b1;
      REQ_POP_FRONT:  is_front = 1'b1;
      REQ_POP_BACK:   is_front = 1'b0;
      default:        is_push  = 1'b0;
    endcase
  end

  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);
  assign push_ok = is_push && !full;
  assign pop_ok  = !is_push && !empty;

  assign wr_addr = is_front ? front_dec : back_q;
  assign rd_addr = is_front ? front_q : back_dec;

  // Next index, count and status
  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    count_d = count_q;
    stat_d  = ST_OK;
    if (is_push) begin
      if (full) begin
        stat_d = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
        if (is_front) front_d = front_dec;
        else          back_d  = back_inc;
      end
    end else begin
      if (empty) begin
        stat_d = ST_EMPTY;
      end else begin
        count_d = count_q - 1'b1;
        if (is_front) front_d = front_inc;
        else          back_d  = back_dec;
      end
    end
  end

  // Control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  // Request capture, commit flags and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      val_q <= push_value_i;
    end
    if (cmd_i.exec) begin
      stat_q   <= stat_d;
      pop_ok_q <= pop_ok;
    end
    if (cmd_i.fill) begin
      res_q      <= pop_ok_q ? $signed(rd_q) : '0;
      res_stat_q <= stat_q;
      res_occ_q  <= OCC_W'(count_q);
    end
  end

  // Circular store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push_ok) begin
      mem[wr_addr] <= val_q;
    end
    if (cmd_i.exec) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign result_value_o = res_q;
  assign status_o       = res_stat_q;
  assign occupancy_o    = res_occ_q;

endmodule

`default_nettype wire

/* hw/rtl/bdq_checker.sv */
// Port-level checks for bounded_deque, attached by bind.
// Depends on bdq_pkg.
`default_nettype none

module bdq_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       req_valid_i,
  input wire logic                       req_ready_i,
  input wire logic                       rsp_valid_i,
  input wire logic                       rsp_ready_i,
  input wire logic signed [31:0]         rsp_result_value_i,
  input wire bdq_pkg::status_e           rsp_status_i,
  input wire logic [bdq_pkg::OCC_W-1:0]  rsp_occupancy_i
);
  import bdq_pkg::*;

  // Held response stays put until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_result_value_i))
    else $error("response changed while stalled");

  // One request in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted back to back");

  // Refused pop: zero value and an empty queue
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_EMPTY |->
      rsp_result_value_i == '0 && rsp_occupancy_i == '0)
    else $error("empty status with data or occupancy");

  // Refused push: zero value and a full queue
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_FULL |->
      rsp_result_value_i == '0 && rsp_occupancy_i == OCC_W'(DEPTH))
    else $error("full status without full occupancy");

  // Occupancy never beyond capacity
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_occupancy_i <= OCC_W'(DEPTH))
    else $error("occupancy beyond capacity");

endmodule

bind bounded_deque bdq_checker u_bdq_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_result_value_i (rsp_o.result_value),
  .rsp_status_i       (rsp_o.status),
  .rsp_occupancy_i    (rsp_o.occupancy)
);

`default_nettype wire
